@@ hdl/gmorph_pkg.sv @@
// Shared types, constants and register codes of the 3x3 grayscale morphology block.
package gmorph_pkg;

    // Pixel and window geometry
    localparam int PIX_W    = 8;
    localparam int TAPS     = 9;
    localparam logic [PIX_W-1:0] PIX_ONES = 8'hFF;

    // Configuration register widths and port layout
    localparam int CFG_WIDTH_W  = 12;
    localparam int CFG_HEIGHT_W = 13;
    localparam int CFG_MASK_W   = 9;
    localparam int CFG_DATA_W   = 13;
    localparam int CFG_IDX_W    = 2;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MODE         = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ELEMENT_MASK = 2'd3;

    // Register reset values
    localparam logic [CFG_WIDTH_W-1:0]  RST_IMAGE_WIDTH  = 12'd640;
    localparam logic [CFG_HEIGHT_W-1:0] RST_IMAGE_HEIGHT = 13'd480;
    localparam logic                    RST_MODE         = 1'b0;
    localparam logic [CFG_MASK_W-1:0]   RST_ELEMENT_MASK = 9'h1FF;

    // Mode codes
    localparam logic MODE_DILATE = 1'b0;
    localparam logic MODE_ERODE  = 1'b1;

    // Frame limits
    localparam int MAX_WIDTH_DEF = 2048;
    localparam int ROW_W         = 12;
    localparam logic [CFG_HEIGHT_W-1:0] HEIGHT_MIN   = 13'd3;
    localparam logic [CFG_HEIGHT_W-1:0] HEIGHT_LIMIT = 13'd4096;

    // 3x3 window, positions in raster order
    typedef logic [TAPS-1:0][PIX_W-1:0] t_win;

    // Operation setup handed to the reduction unit
    typedef struct packed {
        logic                  mode;
        logic [CFG_MASK_W-1:0] mask;
    } t_op;

endpackage

@@ hdl/gmorph_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
module gmorph_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/gmorph_reduce.sv @@
// Masked max/min over the nine window taps as a four-level compare tree.
module gmorph_reduce
    import gmorph_pkg::*;
(
    input  t_win             i_win,
    input  t_op              i_op,
    output logic [PIX_W-1:0] o_value
);

    logic [PIX_W-1:0] tap [TAPS];
    logic [PIX_W-1:0] lvl1 [4];
    logic [PIX_W-1:0] lvl2 [2];
    logic [PIX_W-1:0] lvl3;

    // Keep the larger (dilate) or smaller (erode) of two pixels
    function automatic logic [PIX_W-1:0] pick(
        input logic             mode,
        input logic [PIX_W-1:0] a,
        input logic [PIX_W-1:0] b
    );
        logic a_gt;
        a_gt = (a > b);
        if (mode == MODE_ERODE) begin
            pick = a_gt ? b : a;
        end else begin
            pick = a_gt ? a : b;
        end
    endfunction

    // Disabled taps take the neutral value of the operation
    always_comb begin
        for (int i = 0; i < TAPS; i++) begin
            if (i_op.mask[i]) begin
                tap[i] = i_win[i];
            end else begin
                tap[i] = (i_op.mode == MODE_ERODE) ? PIX_ONES : '0;
            end
        end
    end

    // Tree
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            lvl1[i] = pick(i_op.mode, tap[2*i], tap[2*i+1]);
        end
        lvl2[0] = pick(i_op.mode, lvl1[0], lvl1[1]);
        lvl2[1] = pick(i_op.mode, lvl1[2], lvl1[3]);
        lvl3    = pick(i_op.mode, lvl2[0], lvl2[1]);
        o_value = pick(i_op.mode, lvl3, tap[TAPS-1]);
    end

endmodule

@@ hdl/gray_morphology_3x3_masked.sv @@
// Top level of the 3x3 masked grayscale dilation/erosion block.
//
// Takes one 8-bit pixel per clock in raster order, unless stalled, and returns
// one result per interior pixel: the max (dilate) or min (erode) of the 3x3
// window taps enabled by element_mask, (W-2)*(H-2) results per frame. The two
// rows above the current one live in a single line memory (one 16-bit word
// per column), read one column ahead and written back with the shifted column
// as each pixel is taken, so a new pixel is accepted each cycle unless stalled.
// A result is registered in the cycle after its window completes. After reset
// the block stalls its input for one cycle while the first column is fetched.
// The user must write configuration between frames; the block does not check.
module gray_morphology_3x3_masked
    import gmorph_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // pixel input
    input  logic                  i_pix_valid,
    output logic                  o_pix_stall,
    input  logic [PIX_W-1:0]      i_pixel,
    // result output
    output logic                  o_res_valid,
    input  logic                  i_res_stall,
    output logic [PIX_W-1:0]      o_value,
    output logic                  o_row_end,
    output logic                  o_frame_end
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int EW = (CFG_WIDTH_W > $clog2(MAX_WIDTH + 1)) ?
                        CFG_WIDTH_W : $clog2(MAX_WIDTH + 1);
    localparam logic [EW-1:0] W_MIN = EW'(3);
    localparam logic [EW-1:0] W_MAX = EW'(MAX_WIDTH);

    // Configuration registers
    logic [CFG_WIDTH_W-1:0]  r_width;
    logic [CFG_HEIGHT_W-1:0] r_height;
    logic                    r_mode;
    logic [CFG_MASK_W-1:0]   r_mask;

    // Position, window and priming state
    logic [CW-1:0]    r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    logic [PIX_W-1:0] r_win [6];
    logic             r_primed;

    // Output register
    logic             r_out_valid;
    logic [PIX_W-1:0] r_out_value;
    logic             r_out_row_end;
    logic             r_out_frame_end;

    logic [EW-1:0]           eff_w;
    logic [EW-1:0]           width_ext;
    logic [CFG_HEIGHT_W-1:0] eff_h;
    logic                    accept;
    logic                    row_last;
    logic                    frame_last;
    logic                    emit;
    logic [2*PIX_W-1:0]      ram_rdata;
    logic [PIX_W-1:0]        above;
    logic [PIX_W-1:0]        above2;
    logic                    ram_re;
    logic [CW-1:0]           ram_raddr;
    t_win                    win;
    t_op                     op;
    logic [PIX_W-1:0]        red_value;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= RST_IMAGE_WIDTH;
            r_height <= RST_IMAGE_HEIGHT;
            r_mode   <= RST_MODE;
            r_mask   <= RST_ELEMENT_MASK;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_IMAGE_WIDTH:  r_width  <= i_cfg_data[CFG_WIDTH_W-1:0];
                REG_IMAGE_HEIGHT: r_height <= i_cfg_data[CFG_HEIGHT_W-1:0];
                REG_MODE:         r_mode   <= i_cfg_data[0];
                REG_ELEMENT_MASK: r_mask   <= i_cfg_data[CFG_MASK_W-1:0];
                default: ;
            endcase
        end
    end

    // Effective frame size
    always_comb begin
        width_ext = EW'(r_width);
        if (width_ext < W_MIN) begin
            eff_w = W_MIN;
        end else if (width_ext > W_MAX) begin
            eff_w = W_MAX;
        end else begin
            eff_w = width_ext;
        end
        if (r_height < HEIGHT_MIN) begin
            eff_h = HEIGHT_MIN;
        end else if (r_height > HEIGHT_LIMIT) begin
            eff_h = HEIGHT_LIMIT;
        end else begin
            eff_h = r_height;
        end
    end

    // Handshake: the output register decouples the two sides
    assign o_pix_stall = !r_primed || (r_out_valid && i_res_stall);
    assign accept      = i_pix_valid && !o_pix_stall;

    // Position in frame
    always_comb begin
        row_last   = (EW'(r_col) + EW'(1)) >= eff_w;
        frame_last = row_last &&
                     ((CFG_HEIGHT_W'(r_row) + CFG_HEIGHT_W'(1)) >= eff_h);
        emit       = (r_col >= CW'(2)) && (r_row >= ROW_W'(2));
        n_col      = row_last ? '0 : r_col + CW'(1);
        n_row      = frame_last ? '0 : r_row + ROW_W'(1);
    end

    // Line memory: [15:8] row two above, [7:0] row above; read one column ahead
    assign ram_re    = accept || !r_primed;
    assign ram_raddr = accept ? n_col : r_col;
    assign above     = ram_rdata[PIX_W-1:0];
    assign above2    = ram_rdata[2*PIX_W-1:PIX_W];

    gmorph_ram #(
        .WIDTH (2*PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (accept),
        .i_waddr (r_col),
        .i_wdata ({above, i_pixel}),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Window assembly
    always_comb begin
        win[0] = r_win[0];
        win[1] = r_win[1];
        win[2] = above2;
        win[3] = r_win[2];
        win[4] = r_win[3];
        win[5] = above;
        win[6] = r_win[4];
        win[7] = r_win[5];
        win[8] = i_pixel;
    end

    assign op.mode = r_mode;
    assign op.mask = r_mask;

    gmorph_reduce u_reduce (
        .i_win   (win),
        .i_op    (op),
        .o_value (red_value)
    );

    // Counters, window shift and priming
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_row    <= '0;
            r_primed <= 1'b0;
            for (int i = 0; i < 6; i++) begin
                r_win[i] <= '0;
            end
        end else begin
            r_primed <= 1'b1;
            if (accept) begin
                r_col    <= n_col;
                r_row    <= row_last ? n_row : r_row;
                r_win[0] <= win[1];
                r_win[1] <= win[2];
                r_win[2] <= win[4];
                r_win[3] <= win[5];
                r_win[4] <= win[7];
                r_win[5] <= win[8];
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept && emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_res_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && emit) begin
            r_out_value     <= red_value;
            r_out_row_end   <= row_last;
            r_out_frame_end <= frame_last;
        end
    end

    assign o_res_valid = r_out_valid;
    assign o_value     = r_out_value;
    assign o_row_end   = r_out_row_end;
    assign o_frame_end = r_out_frame_end;

endmodule

@@ hdl/gmorph_chk.sv @@
// Port-level assertions for the morphology block, bound to its top level.
module gmorph_chk
    import gmorph_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_pix_valid,
    input logic             o_pix_stall,
    input logic             o_res_valid,
    input logic             i_res_stall,
    input logic [PIX_W-1:0] o_value,
    input logic             o_row_end,
    input logic             o_frame_end
);

    // A stalled result holds
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && i_res_stall |=>
            o_res_valid && $stable(o_value) && $stable(o_row_end) &&
            $stable(o_frame_end))
        else $error("stalled result changed");

    // A frame ends only at a row end
    a_frame_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_frame_end |-> o_row_end)
        else $error("frame end without row end");

    // An empty output register never stalls the input once primed
    a_no_idle_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && !o_res_valid |-> !o_pix_stall)
        else $error("input stalled with empty output");

    // A new result follows an accepted pixel
    a_res_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_res_valid) |-> $past(i_pix_valid && !o_pix_stall))
        else $error("result without accepted pixel");

endmodule

bind gray_morphology_3x3_masked gmorph_chk u_gmorph_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_pix_valid (i_pix_valid),
    .o_pix_stall (o_pix_stall),
    .o_res_valid (o_res_valid),
    .i_res_stall (i_res_stall),
    .o_value     (o_value),
    .o_row_end   (o_row_end),
    .o_frame_end (o_frame_end)
);

@@ tb/sv/gray_morphology_3x3_masked_test.sv @@
// Self-checking testbench for the 3x3 masked grayscale dilation/erosion block.
module gray_morphology_3x3_masked_test;
    timeunit 1ns;
    timeprecision 1ps;

    import gmorph_pkg::*;

    localparam int unsigned RANDOM_ITEMS  = 1000;
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned LONG_HOLD     = 300;
    localparam longint     TIMEOUT_NS     = 10_000_000;

    // One output transaction of the block
    typedef struct packed {
        logic [PIX_W-1:0] value;
        logic             row_end;
        logic             frame_end;
    } t_morph_res;

    // One row of the directed table: a register write or a pixel
    typedef struct packed {
        logic                  is_cfg;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        logic [PIX_W-1:0]      px;
        logic                  typed;
        t_morph_res            want;
    } t_dir_row;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx   = REG_IMAGE_WIDTH;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  pix_valid = 1'b0;
    logic                  pix_stall;
    logic [PIX_W-1:0]      pixel     = '0;
    logic                  res_valid;
    logic                  res_stall = 1'b0;
    logic [PIX_W-1:0]      res_value;
    logic                  res_row_end;
    logic                  res_frame_end;

    // Predictor state: shadow registers, line store, window history, counters
    logic [CFG_WIDTH_W-1:0]  reg_width  = RST_IMAGE_WIDTH;
    logic [CFG_HEIGHT_W-1:0] reg_height = RST_IMAGE_HEIGHT;
    logic                    reg_mode   = RST_MODE;
    logic [CFG_MASK_W-1:0]   reg_mask   = RST_ELEMENT_MASK;
    logic [PIX_W-1:0]        line_up1 [0:MAX_WIDTH_DEF-1];
    logic [PIX_W-1:0]        line_up2 [0:MAX_WIDTH_DEF-1];
    logic [PIX_W-1:0]        win_hist [0:5];
    int unsigned             col_cnt = 0;
    int unsigned             row_cnt = 0;

    t_morph_res  morph_due [$];
    t_dir_row    dir_rows [$];
    int unsigned mismatch_count = 0;
    bit          px_burst       = 1'b0;
    bit          res_burst      = 1'b0;
    bit          hold_request   = 1'b0;

    gray_morphology_3x3_masked dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .i_pix_valid (pix_valid),
        .o_pix_stall (pix_stall),
        .i_pixel     (pixel),
        .o_res_valid (res_valid),
        .i_res_stall (res_stall),
        .o_value     (res_value),
        .o_row_end   (res_row_end),
        .o_frame_end (res_frame_end)
    );

    // 4 ns clock
    always begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned lo,
                                              input int unsigned hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Advance the predictor by one pixel; returns 1 when the pixel yields a result
    function automatic bit morph_predict(input logic [PIX_W-1:0] px, output t_morph_res res);
        int unsigned      w;
        int unsigned      h;
        int unsigned      col;
        logic [PIX_W-1:0] tap [0:TAPS-1];
        logic [PIX_W-1:0] acc;
        bit               row_last;
        bit               frame_last;
        bit               has;
        w = clamp_dim(32'(reg_width), 3, MAX_WIDTH_DEF);
        h = clamp_dim(32'(reg_height), 3, 32'(HEIGHT_LIMIT));
        col = col_cnt % MAX_WIDTH_DEF;
        tap[0] = win_hist[0]; tap[1] = win_hist[1]; tap[2] = line_up2[col];
        tap[3] = win_hist[2]; tap[4] = win_hist[3]; tap[5] = line_up1[col];
        tap[6] = win_hist[4]; tap[7] = win_hist[5]; tap[8] = px;
        row_last   = (col_cnt + 1 >= w);
        frame_last = row_last && (row_cnt + 1 >= h);
        res = '0;
        has = 1'b0;
        // masked max or min over the enabled taps
        if (col_cnt >= 2 && row_cnt >= 2) begin
            acc = (reg_mode == MODE_ERODE) ? PIX_ONES : '0;
            for (int i = 0; i < TAPS; i++) begin
                if (reg_mask[i]) begin
                    if (reg_mode == MODE_ERODE) begin
                        if (tap[i] < acc) acc = tap[i];
                    end else begin
                        if (tap[i] > acc) acc = tap[i];
                    end
                end
            end
            res.value     = acc;
            res.row_end   = row_last;
            res.frame_end = frame_last;
            has = 1'b1;
        end
        // shift window left, push the column into the line store
        win_hist[0] = tap[1]; win_hist[1] = tap[2];
        win_hist[2] = tap[4]; win_hist[3] = tap[5];
        win_hist[4] = tap[7]; win_hist[5] = tap[8];
        line_up2[col] = tap[5];
        line_up1[col] = px;
        if (row_last) begin
            col_cnt = 0;
            row_cnt = frame_last ? 0 : ((row_cnt + 1) & 'hFFF);
        end else begin
            col_cnt = col_cnt + 1;
        end
        return has;
    endfunction

    task automatic flag_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
        mismatch_count++;
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
    endtask

    // Output monitor: compare each accepted transaction with the oldest expectation
    always @(posedge clk) begin
        t_morph_res exp_res;
        if (rst_n && res_valid === 1'b1 && !res_stall) begin
            if (morph_due.size() == 0) begin
                flag_mismatch("unexpected result value", 32'(res_value), 0);
            end else begin
                exp_res = morph_due.pop_front();
                if (res_value !== exp_res.value)
                    flag_mismatch("value", 32'(res_value), 32'(exp_res.value));
                if (res_row_end !== exp_res.row_end)
                    flag_mismatch("row_end", 32'(res_row_end), 32'(exp_res.row_end));
                if (res_frame_end !== exp_res.frame_end)
                    flag_mismatch("frame_end", 32'(res_frame_end), 32'(exp_res.frame_end));
            end
        end
    end

    // Result side: random stall before each transaction, one long hold on request
    initial begin
        int unsigned gap;
        wait (rst_n === 1'b1);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                gap = LONG_HOLD;
            end else begin
                gap = res_burst ? 0 : $urandom_range(0, 8);
            end
            if (gap != 0) begin
                res_stall <= 1'b1;
                repeat (gap) @(posedge clk);
            end
            res_stall <= 1'b0;
            @(posedge clk);
            while (res_valid !== 1'b1) @(posedge clk);
            if ($urandom_range(0, 31) == 0) res_burst = !res_burst;
        end
    end

    // Run limit
    initial begin
        #(TIMEOUT_NS);
        $display("** gray_morphology_3x3_masked: FAILED **");
        $finish;
    end

    // Offer one pixel, wait for the handshake, then predict its result
    task automatic send_pixel(input logic [PIX_W-1:0] px, input bit typed,
                              input t_morph_res want);
        int unsigned gap;
        t_morph_res  pred;
        bit          has;
        gap = px_burst ? 0 : $urandom_range(0, 8);
        if (gap != 0) begin
            pix_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix_valid <= 1'b1;
        pixel     <= px;
        @(posedge clk);
        while (pix_stall !== 1'b0) @(posedge clk);
        has = morph_predict(px, pred);
        if (typed) morph_due.push_back(want);
        else if (has) morph_due.push_back(pred);
    endtask

    // Stop offering and wait until every expected result has come back
    task automatic wait_for_results();
        pix_valid <= 1'b0;
        do @(posedge clk); while (morph_due.size() != 0);
    endtask

    task automatic drain_results();
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Register write; the caller lowers the write enable after the last one
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
        case (idx)
            REG_IMAGE_WIDTH:  reg_width  = data[CFG_WIDTH_W-1:0];
            REG_IMAGE_HEIGHT: reg_height = data[CFG_HEIGHT_W-1:0];
            REG_MODE:         reg_mode   = data[0];
            REG_ELEMENT_MASK: reg_mask   = data[CFG_MASK_W-1:0];
            default: ;
        endcase
    endtask

    task automatic setup_phase(input int unsigned w, input int unsigned h, input logic md,
                               input logic [CFG_MASK_W-1:0] msk);
        drain_results();
        write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(w));
        write_reg(REG_IMAGE_HEIGHT, CFG_DATA_W'(h));
        write_reg(REG_MODE, CFG_DATA_W'(md));
        write_reg(REG_ELEMENT_MASK, CFG_DATA_W'(msk));
        cfg_we <= 1'b0;
    endtask

    // One whole frame; style picks the pixel distribution, pause_at the hold-off point
    task automatic send_frame(input int unsigned w, input int unsigned h,
                              input int unsigned style, input int pause_at);
        logic [PIX_W-1:0] px;
        int               n;
        logic [PIX_W-1:0] base;
        base = PIX_W'($urandom_range(0, 255));
        for (n = 0; n < int'(w * h); n++) begin
            if (n == pause_at) wait_for_results();
            case (style)
                0: px = PIX_W'($urandom_range(0, 255));
                1: begin
                    case ($urandom_range(0, 2))
                        0: px = '0;
                        1: px = PIX_ONES;
                        default: px = PIX_W'($urandom_range(0, 255));
                    endcase
                end
                default: px = base ^ PIX_W'($urandom_range(0, 3));
            endcase
            send_pixel(px, 1'b0, '0);
        end
    endtask

    // Directed table builders
    task automatic row_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        t_dir_row r;
        r = '0;
        r.is_cfg = 1'b1;
        r.idx    = idx;
        r.data   = data;
        dir_rows.push_back(r);
    endtask

    task automatic row_pix(input logic [PIX_W-1:0] px);
        t_dir_row r;
        r = '0;
        r.px = px;
        dir_rows.push_back(r);
    endtask

    task automatic row_pix_out(input logic [PIX_W-1:0] px, input logic [PIX_W-1:0] value,
                               input logic re, input logic fe);
        t_dir_row r;
        r = '0;
        r.px             = px;
        r.typed          = 1'b1;
        r.want.value     = value;
        r.want.row_end   = re;
        r.want.frame_end = fe;
        dir_rows.push_back(r);
    endtask

    // Main stimulus
    initial begin
        bit                    writing;
        int unsigned           sent;
        int unsigned           phase;
        int unsigned           w;
        int unsigned           h;
        int unsigned           w_eff;
        int unsigned           h_eff;
        int unsigned           frames;
        logic                  md;
        logic [CFG_MASK_W-1:0] msk;

        for (int i = 0; i < MAX_WIDTH_DEF; i++) begin
            line_up1[i] = '0;
            line_up2[i] = '0;
        end
        for (int i = 0; i < 6; i++) win_hist[i] = '0;

        // Width and height below range clamp to 3x3; reset mode and mask give full max
        row_cfg(REG_IMAGE_WIDTH, CFG_DATA_W'(0));
        row_cfg(REG_IMAGE_HEIGHT, CFG_DATA_W'(2));
        row_pix(8'd0); row_pix(8'd1); row_pix(8'd2);
        row_pix(8'd3); row_pix(8'd4); row_pix(8'd5);
        row_pix(8'd6); row_pix(8'd7); row_pix_out(8'd255, 8'd255, 1'b1, 1'b1);
        // Empty mask while eroding gives all ones
        row_cfg(REG_MODE, CFG_DATA_W'(MODE_ERODE));
        row_cfg(REG_ELEMENT_MASK, CFG_DATA_W'(0));
        row_pix(8'd12); row_pix(8'd0);  row_pix(8'd34);
        row_pix(8'd56); row_pix(8'd0);  row_pix(8'd78);
        row_pix(8'd90); row_pix(8'd0);  row_pix_out(8'd1, 8'd255, 1'b1, 1'b1);
        // Empty mask while dilating gives zero
        row_cfg(REG_MODE, CFG_DATA_W'(MODE_DILATE));
        row_pix(8'd255); row_pix(8'd200); row_pix(8'd255);
        row_pix(8'd128); row_pix(8'd255); row_pix(8'd64);
        row_pix(8'd255); row_pix(8'd1);   row_pix_out(8'd255, 8'd0, 1'b1, 1'b1);
        // Width above range: no row end within the first row, then shrink to 3 mid-row
        row_cfg(REG_IMAGE_WIDTH, CFG_DATA_W'(12'hFFF));
        row_cfg(REG_ELEMENT_MASK, CFG_DATA_W'(9'h1FF));
        for (int i = 0; i < 20; i++) row_pix(PIX_W'(i * 37 + 5));
        row_cfg(REG_IMAGE_WIDTH, CFG_DATA_W'(3));
        row_pix(8'd200);
        row_pix(8'd9);  row_pix(8'd18); row_pix(8'd27);
        row_pix(8'd36); row_pix(8'd45); row_pix(8'd54);
        // Height above range: no frame end at row 2, then shrink to 3 so row 3 ends it
        row_cfg(REG_IMAGE_HEIGHT, CFG_DATA_W'(13'h1FFF));
        row_pix(8'd10); row_pix(8'd20);  row_pix(8'd30);
        row_pix(8'd40); row_pix(8'd250); row_pix(8'd60);
        row_pix(8'd70); row_pix(8'd80);  row_pix_out(8'd90, 8'd250, 1'b1, 1'b0);
        row_cfg(REG_IMAGE_HEIGHT, CFG_DATA_W'(3));
        row_pix(8'd100); row_pix(8'd110); row_pix_out(8'd120, 8'd250, 1'b1, 1'b1);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed table
        writing = 1'b0;
        foreach (dir_rows[k]) begin
            if (dir_rows[k].is_cfg) begin
                if (!writing) drain_results();
                write_reg(dir_rows[k].idx, dir_rows[k].data);
                writing = 1'b1;
            end else begin
                if (writing) cfg_we <= 1'b0;
                writing = 1'b0;
                send_pixel(dir_rows[k].px, dir_rows[k].typed, dir_rows[k].want);
            end
        end

        // Random frames, a few back to back per setting
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0: w = $urandom_range(0, 2);
                1: w = $urandom_range(11, 48);
                default: w = $urandom_range(3, 10);
            endcase
            h  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 7);
            md = 1'($urandom_range(0, 1));
            case ($urandom_range(0, 7))
                0: msk = '0;
                1: msk = '1;
                default: msk = CFG_MASK_W'($urandom_range(0, 511));
            endcase
            px_burst = ($urandom_range(0, 3) == 0);
            if (phase == 0) begin
                // output held off for a long stretch while pixels keep coming
                w = 30;
                h = 6;
                px_burst = 1'b1;
            end else if (phase == 1) begin
                w = 12;
                h = 5;
            end
            setup_phase(w, h, md, msk);
            if (phase == 0) hold_request = 1'b1;
            w_eff  = clamp_dim(w, 3, MAX_WIDTH_DEF);
            h_eff  = clamp_dim(h, 3, 32'(HEIGHT_LIMIT));
            frames = $urandom_range(1, 3);
            for (int f = 0; f < int'(frames); f++)
                send_frame(w_eff, h_eff, $urandom_range(0, 2),
                           (phase == 1 && f == 0) ? 40 : -1);
            sent  += frames * w_eff * h_eff;
            phase++;
        end

        drain_results();
        if (mismatch_count == 0) begin
            $display("** gray_morphology_3x3_masked: PASSED **");
        end else begin
            $display("** gray_morphology_3x3_masked: FAILED **");
        end
        $finish;
    end

endmodule

@@ files.f @@
hdl/gmorph_pkg.sv
hdl/gmorph_ram.sv
hdl/gmorph_reduce.sv
hdl/gray_morphology_3x3_masked.sv
hdl/gmorph_chk.sv
tb/sv/gray_morphology_3x3_masked_test.sv
